FILE: design/tdsrg_pkg.sv
// package for the tangent drive step rate generator
// holds state codes, register indexes, fixed constants and the cordic angle table
// no dependencies
package tdsrg_pkg;

  typedef enum logic [14:0] {
    ST_IDLE  = 15'b000000000000001,
    ST_ANG   = 15'b000000000000010,
    ST_RAD0  = 15'b000000000000100,
    ST_RAD1  = 15'b000000000001000,
    ST_CINIT = 15'b000000000010000,
    ST_CORD  = 15'b000000000100000,
    ST_CEND  = 15'b000000001000000,
    ST_DIV   = 15'b000000010000000,
    ST_EXT0  = 15'b000000100000000,
    ST_EXT1  = 15'b000001000000000,
    ST_EXTF  = 15'b000010000000000,
    ST_STM0  = 15'b000100000000000,
    ST_STM1  = 15'b001000000000000,
    ST_SDIV  = 15'b010000000000000,
    ST_FIN   = 15'b100000000000000
  } state_t;

  typedef enum logic [1:0] {
    DK_TAN = 2'd0,
    DK_RPM = 2'd1,
    DK_STP = 2'd2
  } div_kind_t;

  localparam logic [1:0] REG_HINGE = 2'd0;
  localparam logic [1:0] REG_PITCH = 2'd1;
  localparam logic [1:0] REG_SPR   = 2'd2;

  localparam logic [19:0] HINGE_RST = 20'd287000;
  localparam logic [13:0] PITCH_RST = 14'd1250;
  localparam logic [15:0] SPR_RST   = 16'd200;

  localparam logic [27:0] RATE_Q24    = 28'd4205788;
  localparam logic [27:0] DEG2RAD_Q32 = 28'd74961321;
  localparam int          CORDIC_ITERS = 28;
  localparam logic [39:0] EXT_MAX   = 40'hFF_FFFF_FFFF;
  localparam logic [31:0] RPM_MAX   = 32'hFFFF_FFFF;
  localparam logic [30:0] STEPS_MAX = 31'h7FFF_FFFF;

  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:    v = 30'd843314856;
      5'd1:    v = 30'd497837829;
      5'd2:    v = 30'd263043836;
      5'd3:    v = 30'd133525158;
      5'd4:    v = 30'd67021686;
      5'd5:    v = 30'd33543515;
      5'd6:    v = 30'd16775850;
      5'd7:    v = 30'd8388437;
      5'd8:    v = 30'd4194282;
      5'd9:    v = 30'd2097149;
      5'd10:   v = 30'd1048575;
      5'd11:   v = 30'd524287;
      5'd12:   v = 30'd262143;
      5'd13:   v = 30'd131071;
      5'd14:   v = 30'd65535;
      5'd15:   v = 30'd32767;
      5'd16:   v = 30'd16383;
      5'd17:   v = 30'd8191;
      5'd18:   v = 30'd4095;
      5'd19:   v = 30'd2047;
      5'd20:   v = 30'd1023;
      5'd21:   v = 30'd511;
      5'd22:   v = 30'd255;
      5'd23:   v = 30'd127;
      5'd24:   v = 30'd63;
      5'd25:   v = 30'd31;
      5'd26:   v = 30'd15;
      5'd27:   v = 30'd7;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/tangent_drive_step_rate_generator_core.sv
// tangent drive step rate generator, top level
// sequencer around one shared multiplier, cordic stage and restoring divider
// depends on tdsrg_pkg
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_stall, in_restart          | input transaction
//  out     | out_valid, out_stall, out_* result      | result transaction
//  cfg     | cfg_we, cfg_index, cfg_data             | register write
//
// one transaction runs 28 cordic iterations, a 65-step divide for the tangent and two
// 40-step divides for the rates, on the single restoring divider and the single
// 28x28 multiplier
// in_stall is high from acceptance until the result moves to the output register
// a new transaction is taken while a result still waits on out_stall
// reset is synchronous active low and loads the register defaults
module tangent_drive_step_rate_generator_core #(
  parameter int MAX_MINUTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  out_minute,
  output logic [30:0] out_angle_deg_q24,
  output logic [39:0] out_extension_um_q16,
  output logic [31:0] out_rod_rpm_q16,
  output logic [30:0] out_steps_per_minute,
  output logic        out_limit_reached,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  import tdsrg_pkg::*;

  localparam logic [8:0] MaxMin = 9'(MAX_MINUTES);

  state_t      state_r;
  div_kind_t   kind_r;
  logic [19:0] hinge_r;
  logic [13:0] pitch_r;
  logic [15:0] spr_r;
  logic [8:0]  mc_r;
  logic [39:0] prev_r;
  logic [30:0] angle_r;
  logic [76:0] acc_r;
  logic signed [33:0] x_r, y_r, z_r;
  logic [4:0]  it_r;
  logic [64:0] num_r, q_r;
  logic [33:0] dvs_r, rem_r;
  logic [6:0]  cnt_r;
  logic        sat_r;
  logic [39:0] ext_r, delta_r;
  logic [31:0] rpm_r;

  logic        ov_r;
  logic [8:0]  om_r;
  logic [30:0] oang_r, ostp_r;
  logic [39:0] oext_r;
  logic [31:0] orpm_r;
  logic        olim_r;

  logic [27:0] mul_a, mul_b;
  logic [55:0] prod;
  logic [34:0] rem2;
  logic        ge;
  logic signed [33:0] dx, dy, at;
  logic [39:0] ext_v, delta_v;
  logic        out_free, accept;
  logic [32:0] uy;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !ov_r || !out_stall;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_ANG: begin
        mul_a = {19'd0, mc_r};
        mul_b = RATE_Q24;
      end
      ST_RAD0: begin
        mul_a = {12'd0, acc_r[15:0]};
        mul_b = DEG2RAD_Q32;
      end
      ST_RAD1: begin
        mul_a = {13'd0, angle_r[30:16]};
        mul_b = DEG2RAD_Q32;
      end
      ST_EXT0: begin
        mul_a = {8'd0, hinge_r};
        mul_b = q_r[27:0];
      end
      ST_EXT1: begin
        mul_a = {8'd0, hinge_r};
        mul_b = q_r[55:28];
      end
      ST_STM0: begin
        mul_a = {8'd0, delta_r[19:0]};
        mul_b = {12'd0, spr_r};
      end
      ST_STM1: begin
        mul_a = {8'd0, delta_r[39:20]};
        mul_b = {12'd0, spr_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign rem2 = {rem_r, num_r[64]};
  assign ge   = rem2 >= {1'b0, dvs_r};

  assign dx = y_r >>> it_r;
  assign dy = x_r >>> it_r;
  assign at = 34'(atan_q30(it_r));
  assign uy = (y_r > 0) ? y_r[32:0] : 33'd0;

  always_comb begin
    if (sat_r || (acc_r[76:56] != '0)) begin
      ext_v = EXT_MAX;
    end else begin
      ext_v = acc_r[55:16];
    end
    delta_v = (ext_v > prev_r) ? (ext_v - prev_r) : 40'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      hinge_r <= HINGE_RST;
      pitch_r <= PITCH_RST;
      spr_r   <= SPR_RST;
      mc_r    <= '0;
      prev_r  <= '0;
      ov_r    <= 1'b0;
      kind_r  <= DK_TAN;
      sat_r   <= 1'b0;
      cnt_r   <= '0;
      it_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HINGE: hinge_r <= cfg_data;
          REG_PITCH: pitch_r <= cfg_data[13:0];
          REG_SPR:   spr_r   <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (ov_r && !out_stall && !((state_r == ST_FIN) && out_free)) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_restart) begin
              mc_r   <= 9'd1;
              prev_r <= '0;
            end else if (mc_r < MaxMin) begin
              mc_r <= mc_r + 9'd1;
            end
            state_r <= ST_ANG;
          end
        end
        ST_ANG: begin
          acc_r   <= {21'd0, prod};
          state_r <= ST_RAD0;
        end
        ST_RAD0: begin
          angle_r <= acc_r[30:0];
          acc_r   <= {21'd0, prod};
          state_r <= ST_RAD1;
        end
        ST_RAD1: begin
          acc_r   <= acc_r + {5'd0, prod, 16'd0};
          state_r <= ST_CINIT;
        end
        ST_CINIT: begin
          x_r     <= 34'sd1073741824;
          y_r     <= '0;
          z_r     <= $signed({1'b0, acc_r[58:26]});
          it_r    <= '0;
          state_r <= ST_CORD;
        end
        ST_CORD: begin
          if (z_r >= 0) begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - at;
          end else begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + at;
          end
          it_r <= it_r + 5'd1;
          if (it_r == 5'(CORDIC_ITERS - 1)) begin
            state_r <= ST_CEND;
          end
        end
        ST_CEND: begin
          sat_r  <= (x_r <= 0);
          num_r  <= {uy, 32'd0};
          dvs_r  <= x_r;
          rem_r  <= '0;
          q_r    <= '0;
          cnt_r  <= 7'd65;
          kind_r <= DK_TAN;
          if (x_r <= 0) begin
            state_r <= ST_EXT0;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          num_r <= {num_r[63:0], 1'b0};
          rem_r <= ge ? 34'(rem2 - {1'b0, dvs_r}) : rem2[33:0];
          q_r   <= {q_r[63:0], ge};
          cnt_r <= cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            case (kind_r)
              DK_TAN:  state_r <= ST_EXT0;
              DK_RPM:  state_r <= ST_STM0;
              DK_STP:  state_r <= ST_FIN;
              default: state_r <= ST_FIN;
            endcase
          end
        end
        ST_EXT0: begin
          if ((hinge_r != '0) && (q_r[64:56] != '0)) begin
            sat_r <= 1'b1;
          end
          acc_r   <= {21'd0, prod};
          state_r <= ST_EXT1;
        end
        ST_EXT1: begin
          acc_r   <= acc_r + {1'b0, prod[47:0], 28'd0};
          state_r <= ST_EXTF;
        end
        ST_EXTF: begin
          ext_r   <= ext_v;
          delta_r <= delta_v;
          if (pitch_r == '0) begin
            rpm_r   <= RPM_MAX;
            q_r     <= {34'd0, STEPS_MAX};
            state_r <= ST_FIN;
          end else begin
            num_r   <= {delta_v, 25'd0};
            dvs_r   <= {20'd0, pitch_r};
            rem_r   <= '0;
            q_r     <= '0;
            cnt_r   <= 7'd40;
            kind_r  <= DK_RPM;
            state_r <= ST_DIV;
          end
        end
        ST_STM0: begin
          rpm_r   <= (q_r[39:32] != '0) ? RPM_MAX : q_r[31:0];
          acc_r   <= {21'd0, prod};
          state_r <= ST_STM1;
        end
        ST_STM1: begin
          acc_r   <= acc_r + {1'b0, prod, 20'd0};
          state_r <= ST_SDIV;
        end
        ST_SDIV: begin
          num_r   <= {acc_r[55:16], 25'd0};
          rem_r   <= '0;
          q_r     <= '0;
          cnt_r   <= 7'd40;
          kind_r  <= DK_STP;
          state_r <= ST_DIV;
        end
        ST_FIN: begin
          if (out_free) begin
            ov_r    <= 1'b1;
            om_r    <= mc_r;
            oang_r  <= angle_r;
            oext_r  <= ext_r;
            orpm_r  <= rpm_r;
            ostp_r  <= (q_r[64:31] != '0) ? STEPS_MAX : q_r[30:0];
            olim_r  <= (mc_r == MaxMin);
            prev_r  <= ext_r;
            sat_r   <= 1'b0;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid            = ov_r;
  assign out_minute           = om_r;
  assign out_angle_deg_q24    = oang_r;
  assign out_extension_um_q16 = oext_r;
  assign out_rod_rpm_q16      = orpm_r;
  assign out_steps_per_minute = ostp_r;
  assign out_limit_reached    = olim_r;

endmodule

FILE: tb/tdsrg_checker.sv
// result checker for the tangent drive step rate generator
// tracks register writes, predicts each result and compares it with the output channel
// depends on tdsrg_pkg
`timescale 1ns / 100ps
module tdsrg_checker #(
  parameter int MAX_MINUTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_restart,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [8:0]  out_minute,
  input  logic [30:0] out_angle_deg_q24,
  input  logic [39:0] out_extension_um_q16,
  input  logic [31:0] out_rod_rpm_q16,
  input  logic [30:0] out_steps_per_minute,
  input  logic        out_limit_reached,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output int          errors,
  output int          pending
);
  import tdsrg_pkg::*;

  typedef struct packed {
    logic [8:0]  minute;
    logic [30:0] angle;
    logic [39:0] ext;
    logic [31:0] rpm;
    logic [30:0] steps;
    logic        limit;
  } rate_result_t;

  localparam longint ARC_TAB [28] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
    127, 63, 31, 15, 7
  };

  logic [19:0]  hinge;
  logic [13:0]  pitch;
  logic [15:0]  spr;
  logic [8:0]   minute_cnt;
  logic [39:0]  prev_ext;
  rate_result_t expected_rates[$];

  assign pending = expected_rates.size();

  // rod extension for one angle in degrees q24
  function automatic logic [39:0] rod_extension(input logic [30:0] ang);
    longint x, y, z, dx, dy;
    longint unsigned uy, tanv, lim;
    x = 64'sd1 << 30;
    y = 0;
    z = longint'((64'(ang) * 64'(DEG2RAD_Q32)) >> 26);
    for (int i = 0; i < 28; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARC_TAB[i];
      end else begin
        x += dx; y -= dy; z += ARC_TAB[i];
      end
    end
    if (x <= 0) return EXT_MAX;
    uy = (y > 0) ? longint'(y) : 64'd0;
    tanv = (uy << 32) / longint'(x);
    if (hinge != 0) begin
      lim = ((64'd1 << 56) - 1) / 64'(hinge);
      if (tanv > lim) return EXT_MAX;
    end
    return 40'((64'(hinge) * tanv) >> 16);
  endfunction

  always @(posedge clk) begin
    rate_result_t r;
    rate_result_t e;
    longint unsigned delta, rpm, stp;
    if (!rst_n) begin
      hinge <= HINGE_RST;
      pitch <= PITCH_RST;
      spr <= SPR_RST;
      minute_cnt = '0;
      prev_ext = '0;
      errors <= 0;
      expected_rates.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HINGE: hinge <= cfg_data;
          REG_PITCH: pitch <= cfg_data[13:0];
          REG_SPR:   spr <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_restart) begin
          minute_cnt = 9'd1;
          prev_ext = '0;
        end else if (minute_cnt < MAX_MINUTES) begin
          minute_cnt = minute_cnt + 9'd1;
        end
        r.minute = minute_cnt;
        r.angle = 31'(64'(minute_cnt) * 64'(RATE_Q24));
        r.ext = rod_extension(r.angle);
        delta = (r.ext > prev_ext) ? 64'(r.ext - prev_ext) : 64'd0;
        if (pitch == 0) begin
          rpm = RPM_MAX;
          stp = STEPS_MAX;
        end else begin
          rpm = delta / 64'(pitch);
          if (rpm > RPM_MAX) rpm = RPM_MAX;
          stp = (delta * 64'(spr)) / (64'(pitch) << 16);
          if (stp > STEPS_MAX) stp = STEPS_MAX;
        end
        r.rpm = 32'(rpm);
        r.steps = 31'(stp);
        r.limit = (minute_cnt == MAX_MINUTES);
        prev_ext = r.ext;
        expected_rates.push_back(r);
      end
      if (out_valid && !out_stall) begin
        r = {out_minute, out_angle_deg_q24, out_extension_um_q16, out_rod_rpm_q16,
             out_steps_per_minute, out_limit_reached};
        if (expected_rates.size() == 0) begin
          $display("%0t: unexpected result transaction, actual %p", $time, r);
          errors <= errors + 1;
        end else begin
          e = expected_rates.pop_front();
          if (r != e) begin
            $display("%0t: result differs, expected %p, actual %p", $time, e, r);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

FILE: tb/tb.sv
// testbench top for the tangent drive step rate generator
// drives minute ticks, restarts and register writes under varying idle patterns
// depends on tdsrg_pkg, tdsrg_checker and tangent_drive_step_rate_generator_core
`timescale 1ns / 100ps
module tb;
  import tdsrg_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_restart;
  logic        out_valid;
  logic        out_stall;
  logic [8:0]  out_minute;
  logic [30:0] out_angle_deg_q24;
  logic [39:0] out_extension_um_q16;
  logic [31:0] out_rod_rpm_q16;
  logic [30:0] out_steps_per_minute;
  logic        out_limit_reached;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_data;
  int          errors;
  int          pending;
  int          gap_pct;
  int          stall_pct;
  int          restart_per_mille;

  tangent_drive_step_rate_generator_core i_dut (.*);
  tdsrg_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  task automatic send_tick(input logic restart);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic set_regs(input logic [19:0] h, input logic [13:0] p, input logic [15:0] s);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_HINGE;
    cfg_data <= h;
    @(posedge clk);
    cfg_index <= REG_PITCH;
    cfg_data <= 20'(p);
    @(posedge clk);
    cfg_index <= REG_SPR;
    cfg_data <= 20'(s);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int mode, input int n);
    case (mode)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 71; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 71; end
      default: begin gap_pct = 28; stall_pct = 28; end
    endcase
    repeat (n) send_tick($urandom_range(999) < restart_per_mille);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_restart = 1'b0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_HINGE;
    cfg_data = '0;
    gap_pct = 0;
    stall_pct = 0;
    restart_per_mille = 2;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first tick after reset, restarts in a row
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    set_regs(20'd1, 14'd100, 16'd1);
    repeat (3) send_tick(1'b0);
    // zero pitch, widest hinge and step count
    set_regs(20'hFFFFF, 14'd0, 16'hFFFF);
    repeat (3) send_tick(1'b0);
    // hinge lowered mid-run gives a shrinking extension
    set_regs(20'd1000, 14'h3FFF, 16'hFFFF);
    repeat (2) send_tick(1'b0);
    set_regs(HINGE_RST, PITCH_RST, SPR_RST);

    for (int p = 0; p < 8; p++) begin
      if (p == 3)
        set_regs(20'd1000000, 14'd100, 16'd65535);
      else if (p == 6)
        set_regs(20'($urandom_range(1000000, 1)), 14'd0, 16'($urandom_range(65535)));
      else if (p == 7)
        set_regs(20'd1, 14'd10000, 16'd1);
      else
        set_regs(20'($urandom_range(1000000, 1)), 14'($urandom_range(10000, 100)),
                 16'($urandom_range(65535, 1)));
      restart_per_mille = (p == 5) ? 250 : 2;
      run_phase(p % 4, 120);
    end

    drain();
    if (errors == 0)
      $display("tangent_drive_step_rate_generator_core: match");
    else
      $display("tangent_drive_step_rate_generator_core: mismatch");
    $finish;
  end

  initial begin
    #50ms;
    $display("tangent_drive_step_rate_generator_core: mismatch");
    $finish;
  end

endmodule
